// File: design/bpa_pkg.sv
// Constants, command and status codes for the bitmap page allocator.
package bpa_pkg;

  localparam int BITMAP_BYTES  = 512;
  localparam int BITS_PER_BYTE = 8;
  localparam int INDEX_LIMIT   = 4096;
  localparam int BITMAP_BITS   = BITMAP_BYTES * BITS_PER_BYTE;
  localparam int USABLE_PAGES  = (BITMAP_BITS < INDEX_LIMIT) ? BITMAP_BITS : INDEX_LIMIT;

  localparam int PAGE_W  = 12;
  localparam int COUNT_W = 13;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;

  // The bitmap is stored as 64-bit words, eight bytes of the byte view to a word.
  localparam int WORD_W     = 64;
  localparam int BIT_W      = 6;
  localparam int BYTES_PER_WORD = WORD_W / BITS_PER_BYTE;
  localparam int NUM_WORDS  = (USABLE_PAGES + WORD_W - 1) / WORD_W;
  localparam int WADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int GROUP_W    = 8;
  localparam int NUM_GROUPS = (NUM_WORDS + GROUP_W - 1) / GROUP_W;

  localparam logic [COUNT_W-1:0] USABLE_LIMIT = COUNT_W'(USABLE_PAGES);

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL         = 2'd1;
  localparam logic [STAT_W-1:0] ST_ALREADY_FREE = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE        = 2'd3;

endpackage

// File: design/bitmap_page_allocator.sv
// Bitmap page allocator: lowest-free allocate, deallocate and query over a word memory.
//
//   channel | dir | handshake         | payload
//   s_      | in  | s_tvalid/s_tready | s_tdata: page_index; s_tuser: command
//   m_      | out | m_tvalid/m_tready | m_tdata: result_page, allocated_count;
//           |     |                   | m_tuser: status, page_free
//
// Allocate passes through the group, word, scan and pick states: a two-level scan of the per-word
// full flags, one read of the bitmap memory, then a byte pick and a bit pick.
// Deallocate and query take one memory read and answer from the check state; out-of-range
// indexes, unused commands and an allocate on a full bitmap answer from the direct state.
// One command is in flight at a time. Reset clears per-word valid bits, so the
// memory needs no clearing pass. A stalled result holds the block before write-back.
module bitmap_page_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [11:0] page_index, zero filled above
  input  logic [bpa_pkg::CMD_W-1:0] s_tuser,  // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // [11:0] result_page, [24:12] allocated_count, zero filled above
  output logic [2:0]  m_tuser   // [1:0] status, [2] page_free
);
  import bpa_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_GROUP  = 3'd1;
  localparam logic [2:0] S_WORD   = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_PICK   = 3'd4;
  localparam logic [2:0] S_CHECK  = 3'd5;
  localparam logic [2:0] S_DIRECT = 3'd6;

  logic [2:0]          state;
  logic [WORD_W-1:0]   mem [NUM_WORDS];
  logic [WORD_W-1:0]   ram_q;
  logic                mem_re;
  logic [WADDR_W-1:0]  mem_raddr;
  logic                mem_we;
  logic [WADDR_W-1:0]  mem_waddr;
  logic [WORD_W-1:0]   mem_wdata;

  logic [NUM_WORDS-1:0] word_valid;
  logic [NUM_WORDS-1:0] word_full;
  logic [WADDR_W-1:0]   rd_addr;
  logic                 rd_valid;

  logic [CMD_W-1:0]    cmd_r;
  logic [PAGE_W-1:0]   idx_r;
  logic [COUNT_W-1:0]  used_count;

  logic [NUM_GROUPS-1:0] grp_hit;
  logic [2:0]            grp_sel [NUM_GROUPS];
  logic [NUM_GROUPS-1:0] grp_hit_c;
  logic [2:0]            grp_sel_c [NUM_GROUPS];
  logic                  word_found;
  logic [WADDR_W-1:0]    word_pick;

  logic [WORD_W-1:0]         cur_word;
  logic [WORD_W-1:0]         rd_word;
  logic [BYTES_PER_WORD-1:0] byte_hit;
  logic [2:0]                byte_sel [BYTES_PER_WORD];
  logic [BYTES_PER_WORD-1:0] byte_hit_c;
  logic [2:0]                byte_sel_c [BYTES_PER_WORD];
  logic [BIT_W-1:0]          bit_pick;
  logic [WORD_W-1:0]         alloc_word;
  logic [WORD_W-1:0]         clear_word;
  logic                      idx_set;

  logic [STAT_W-1:0]   d_status;
  logic [PAGE_W-1:0]   d_page;

  logic                out_free_slot;
  logic                out_load;
  logic                accept;
  logic                idx_in_range;
  logic [STAT_W-1:0]   out_status;
  logic [PAGE_W-1:0]   out_page;
  logic                out_pfree;
  logic [COUNT_W-1:0]  out_count;

  function automatic logic [WORD_W-1:0] pad_mask(input logic [WADDR_W-1:0] addr);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (int'(addr) * WORD_W + b >= USABLE_PAGES) m[b] = 1'b1;
    end
    return m;
  endfunction

  assign s_tready      = (state == S_IDLE);
  assign accept        = s_tvalid && s_tready;
  assign out_free_slot = !m_tvalid || m_tready;
  assign out_load      = out_free_slot &&
                         (state == S_PICK || state == S_CHECK || state == S_DIRECT);
  assign idx_in_range  = ({1'b0, s_tdata[PAGE_W-1:0]} < USABLE_LIMIT);

  assign m_tdata = {7'b0, out_count, out_page};
  assign m_tuser = {out_pfree, out_status};

  // Bitmap memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) ram_q <= mem[mem_raddr];
  end

  // First non-full word within each group of eight words.
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_hit_c[g] = 1'b0;
      grp_sel_c[g] = '0;
      for (int j = GROUP_W - 1; j >= 0; j--) begin
        if (g * GROUP_W + j < NUM_WORDS) begin
          if (!word_full[g * GROUP_W + j]) begin
            grp_hit_c[g] = 1'b1;
            grp_sel_c[g] = 3'(j);
          end
        end
      end
    end
  end

  always_comb begin
    word_found = 1'b0;
    word_pick  = '0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (grp_hit[g]) begin
        word_found = 1'b1;
        word_pick  = WADDR_W'(g * GROUP_W + int'(grp_sel[g]));
      end
    end
  end

  assign rd_word = rd_valid ? ram_q : '0;

  // First free bit within each byte of the word just read; padding counts as taken.
  always_comb begin
    logic [WORD_W-1:0] eff;
    eff = rd_word | pad_mask(rd_addr);
    for (int k = 0; k < BYTES_PER_WORD; k++) begin
      byte_hit_c[k] = 1'b0;
      byte_sel_c[k] = '0;
      for (int b = BITS_PER_BYTE - 1; b >= 0; b--) begin
        if (!eff[k * BITS_PER_BYTE + b]) begin
          byte_hit_c[k] = 1'b1;
          byte_sel_c[k] = 3'(b);
        end
      end
    end
  end

  always_comb begin
    bit_pick = '0;
    for (int k = BYTES_PER_WORD - 1; k >= 0; k--) begin
      if (byte_hit[k]) bit_pick = BIT_W'(k * BITS_PER_BYTE + int'(byte_sel[k]));
    end
  end

  assign alloc_word = cur_word | (WORD_W'(1) << bit_pick);
  assign clear_word = rd_word & ~(WORD_W'(1) << idx_r[BIT_W-1:0]);
  assign idx_set    = rd_word[idx_r[BIT_W-1:0]];

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = word_pick;
    mem_we    = 1'b0;
    mem_waddr = rd_addr;
    mem_wdata = alloc_word;
    if (accept) begin
      mem_re    = 1'b1;
      mem_raddr = s_tdata[BIT_W+WADDR_W-1:BIT_W];
    end else if (state == S_WORD) begin
      mem_re = word_found;
    end
    if (state == S_PICK && out_free_slot) begin
      mem_we = 1'b1;
    end else if (state == S_CHECK && out_free_slot && cmd_r == CMD_DEALLOC && idx_set) begin
      mem_we    = 1'b1;
      mem_wdata = clear_word;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= s_tuser;
      idx_r <= s_tdata[PAGE_W-1:0];
      if (s_tuser == CMD_ALLOC) begin
        d_page <= '0;
      end else begin
        d_page <= s_tdata[PAGE_W-1:0];
      end
      if ((s_tuser == CMD_DEALLOC || s_tuser == CMD_QUERY) && !idx_in_range) begin
        d_status <= ST_RANGE;
      end else begin
        d_status <= ST_OK;
      end
    end else if (state == S_WORD) begin
      d_status <= ST_FULL;
      d_page   <= '0;
    end
    if (mem_re) begin
      rd_addr  <= mem_raddr;
      rd_valid <= word_valid[mem_raddr];
    end
    if (state == S_GROUP) begin
      grp_hit <= grp_hit_c;
      grp_sel <= grp_sel_c;
    end
    if (state == S_SCAN) begin
      byte_hit <= byte_hit_c;
      byte_sel <= byte_sel_c;
      cur_word <= rd_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      word_valid <= '0;
      word_full  <= '0;
      used_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      m_tvalid <= out_load || (m_tvalid && !m_tready);
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_tuser == CMD_ALLOC) begin
              state <= S_GROUP;
            end else if ((s_tuser == CMD_DEALLOC || s_tuser == CMD_QUERY) && idx_in_range) begin
              state <= S_CHECK;
            end else begin
              state <= S_DIRECT;
            end
          end
        end
        S_GROUP: begin
          state <= S_WORD;
        end
        S_WORD: begin
          state <= word_found ? S_SCAN : S_DIRECT;
        end
        S_SCAN: begin
          state <= S_PICK;
        end
        S_PICK: begin
          if (out_free_slot) begin
            word_valid[rd_addr] <= 1'b1;
            word_full[rd_addr]  <= &(alloc_word | pad_mask(rd_addr));
            used_count <= used_count + 1'b1;
            out_status <= ST_OK;
            out_page   <= PAGE_W'(int'(rd_addr) * WORD_W + int'(bit_pick));
            out_pfree  <= 1'b0;
            out_count  <= used_count + 1'b1;
            state      <= S_IDLE;
          end
        end
        S_CHECK: begin
          if (out_free_slot) begin
            out_page  <= idx_r;
            out_pfree <= (cmd_r == CMD_QUERY) && !idx_set;
            state     <= S_IDLE;
            if (cmd_r == CMD_DEALLOC && !idx_set) begin
              out_status <= ST_ALREADY_FREE;
              out_count  <= used_count;
            end else if (cmd_r == CMD_DEALLOC) begin
              word_valid[rd_addr] <= 1'b1;
              word_full[rd_addr]  <= 1'b0;
              used_count <= used_count - 1'b1;
              out_status <= ST_OK;
              out_count  <= used_count - 1'b1;
            end else begin
              out_status <= ST_OK;
              out_count  <= used_count;
            end
          end
        end
        S_DIRECT: begin
          if (out_free_slot) begin
            out_status <= d_status;
            out_page   <= d_page;
            out_pfree  <= 1'b0;
            out_count  <= used_count;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
